FILE: design/mfhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MQTT fixed-header parser.
// No dependencies.
package mfhp_pkg;

   localparam int LEN_W  = 28;
   localparam int PART_W = 7;
   localparam int LANES  = LEN_W / PART_W;
   localparam int IDX_W  = 4;   // length byte index, covers up to sixteen length bytes
   localparam int HB_W   = 3;

   localparam logic [LEN_W-1:0] LEN_MASK = 28'hFFF_FFFF;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_MALFORMED  = 2'd2;

   typedef enum logic [2:0] {
      OP_FIRST_HOLD,
      OP_FIRST_END,
      OP_LEN_MORE,
      OP_LEN_OK,
      OP_LEN_MALFORMED,
      OP_LEN_END
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       data;
      logic [IDX_W-1:0] idx;
   } entry_type;

endpackage

FILE: design/mfhp_if.sv
`timescale 1ns / 1ps
// Handshake channels of the MQTT fixed-header parser: header bytes in, results out.
// Depends on mfhp_pkg.
interface mfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buf_end;

   modport source (output valid, output data_byte, output buf_end, input ready);
   modport sink   (input valid, input data_byte, input buf_end, output ready);
endinterface

interface mfhp_rsp_if;
   import mfhp_pkg::*;
   logic             valid;
   logic             ready;
   logic [3:0]       msg_type;
   logic             dup_flag;
   logic [1:0]       qos_level;
   logic             retain_flag;
   logic [LEN_W-1:0] remaining_length;
   logic [HB_W-1:0]  header_bytes;
   logic [1:0]       parse_status;

   modport source (output valid, output msg_type, output dup_flag, output qos_level,
                   output retain_flag, output remaining_length, output header_bytes,
                   output parse_status, input ready);
   modport sink   (input valid, input msg_type, input dup_flag, input qos_level,
                   input retain_flag, input remaining_length, input header_bytes,
                   input parse_status, output ready);
endinterface

FILE: design/mqtt_fixed_header_parser_core.sv
`timescale 1ns / 1ps
// MQTT fixed-header parser, top level. Takes one header byte per word on req_ch and
// returns one result word on rsp_ch per header: packet type and flags, the decoded
// remaining length, the header byte count and a status (ok, incomplete, malformed).
// A new byte is taken every cycle while the result side keeps up; the byte that
// closes the header passes through the two-entry queue between the byte classifier
// and the length accumulator, and its result then through the output register that
// drives rsp_ch. A stalled result holds back the queue, and the input stalls
// once the queue is full. Depends on mfhp_pkg, mfhp_if, mfhp_front, mfhp_queue and
// mfhp_back.
module mqtt_fixed_header_parser_core import mfhp_pkg::*; #(
   parameter int MAX_LEN_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   mfhp_req_if.sink   req_ch,
   mfhp_rsp_if.source rsp_ch
);

   logic      push, full, pop, not_empty;
   entry_type push_entry, head;

   mfhp_front #(.MAX_LEN_BYTES(MAX_LEN_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .full       (full),
      .push       (push),
      .push_entry (push_entry)
   );

   mfhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   mfhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: design/mfhp_front.sv
`timescale 1ns / 1ps
// Front end: accepts header bytes and tags each with its role in the header.
// Depends on mfhp_pkg and mfhp_req_if.
module mfhp_front import mfhp_pkg::*; #(
   parameter int MAX_LEN_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   mfhp_req_if.sink   req_ch,
   input  logic       full,
   output logic       push,
   output entry_type  push_entry
);

   logic             in_length_ff, in_length_in;
   logic [IDX_W-1:0] count_ff, count_in;
   op_type           op;

   assign req_ch.ready = !full;
   assign push         = req_ch.valid && !full;

   always_comb begin
      if (!in_length_ff) begin
         op = req_ch.buf_end ? OP_FIRST_END : OP_FIRST_HOLD;
      end else if (!req_ch.data_byte[7]) begin
         op = OP_LEN_OK;
      end else if (count_ff == IDX_W'(MAX_LEN_BYTES - 1)) begin
         op = OP_LEN_MALFORMED;
      end else if (req_ch.buf_end) begin
         op = OP_LEN_END;
      end else begin
         op = OP_LEN_MORE;
      end
   end

   assign push_entry = '{op: op, data: req_ch.data_byte, idx: count_ff};

   always_comb begin
      in_length_in = in_length_ff;
      count_in     = count_ff;
      if (push) begin
         case (op)
            OP_FIRST_HOLD: begin
               in_length_in = 1'b1;
               count_in     = '0;
            end
            OP_LEN_MORE: begin
               count_in = count_ff + IDX_W'(1);
            end
            default: begin
               in_length_in = 1'b0;
               count_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_length_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_length_ff <= in_length_in;
         count_ff     <= count_in;
      end
   end

endmodule

FILE: design/mfhp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of tagged words between front and back end.
// Depends on mfhp_pkg.
module mfhp_queue import mfhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/mfhp_back.sv
`timescale 1ns / 1ps
// Back end: accumulates the remaining length and registers the result word.
// Depends on mfhp_pkg and mfhp_rsp_if.
module mfhp_back import mfhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      not_empty,
   input  entry_type head,
   output logic      pop,
   mfhp_rsp_if.source rsp_ch
);

   logic [7:0]       first_ff, first_in;
   logic [LEN_W-1:0] accum_ff, accum_in;
   logic [LEN_W-1:0] merged;
   logic [PART_W-1:0] part;
   logic [IDX_W-1:0] hb_sum;
   logic             needs_out, out_free, load;

   logic             valid_ff;
   logic [7:0]       res_first_ff, res_first_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;
   logic [HB_W-1:0]  res_hb_ff, res_hb_in;
   logic [1:0]       res_st_ff, res_st_in;

   assign needs_out = (head.op != OP_FIRST_HOLD) && (head.op != OP_LEN_MORE);
   assign out_free  = !valid_ff || rsp_ch.ready;
   assign pop       = not_empty && (!needs_out || out_free);
   assign load      = pop && needs_out;

   assign part   = head.data[PART_W-1:0];
   assign hb_sum = head.idx + IDX_W'(2);

   // bytes past the fourth can only push the length beyond 28 bits
   always_comb begin
      merged = accum_ff;
      for (int i = 0; i < LANES; i++) begin
         if (head.idx == IDX_W'(i)) begin
            merged[i*PART_W +: PART_W] = accum_ff[i*PART_W +: PART_W] | part;
         end
      end
      if ((head.idx >= IDX_W'(LANES)) && (part != '0)) begin
         merged = LEN_MASK;
      end
   end

   always_comb begin
      first_in     = first_ff;
      accum_in     = accum_ff;
      res_first_in = first_ff;
      res_len_in   = '0;
      res_hb_in    = '0;
      res_st_in    = ST_INCOMPLETE;
      case (head.op)
         OP_FIRST_HOLD: begin
            first_in = head.data;
            accum_in = '0;
         end
         OP_FIRST_END: begin
            res_first_in = head.data;
         end
         OP_LEN_MORE: begin
            accum_in = merged;
         end
         OP_LEN_OK: begin
            res_len_in = merged;
            res_hb_in  = hb_sum[HB_W-1:0];
            res_st_in  = ST_OK;
         end
         OP_LEN_MALFORMED: begin
            res_st_in = ST_MALFORMED;
         end
         default: begin
            res_st_in = ST_INCOMPLETE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         first_ff <= first_in;
         accum_ff <= accum_in;
      end
      if (load) begin
         res_first_ff <= res_first_in;
         res_len_ff   <= res_len_in;
         res_hb_ff    <= res_hb_in;
         res_st_ff    <= res_st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.msg_type         = res_first_ff[7:4];
   assign rsp_ch.dup_flag         = res_first_ff[3];
   assign rsp_ch.qos_level        = res_first_ff[2:1];
   assign rsp_ch.retain_flag      = res_first_ff[0];
   assign rsp_ch.remaining_length = res_len_ff;
   assign rsp_ch.header_bytes     = res_hb_ff;
   assign rsp_ch.parse_status     = res_st_ff;

endmodule

FILE: design/mfhp_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the MQTT fixed-header parser.
// Depends on mfhp_pkg; bound to mqtt_fixed_header_parser_core.
module mfhp_checker import mfhp_pkg::*; #(
   parameter int MAX_LEN_BYTES = 4
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [3:0]       rsp_msg_type,
   input logic [LEN_W-1:0] rsp_remaining_length,
   input logic [HB_W-1:0]  rsp_header_bytes,
   input logic [1:0]       rsp_parse_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_msg_type)
         && $stable(rsp_remaining_length) && $stable(rsp_parse_status))
      else $error("result word changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status != ST_OK)
         |-> (rsp_remaining_length == '0) && (rsp_header_bytes == '0))
      else $error("failed parse carries length or byte count");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == ST_OK)
         |-> (MAX_LEN_BYTES > 6) || ((rsp_header_bytes != 3'd0) && (rsp_header_bytes != 3'd1)))
      else $error("ok header shorter than two bytes");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == ST_OK) && (rsp_header_bytes == 3'd2)
         |-> (MAX_LEN_BYTES > 6) || (rsp_remaining_length < 28'd128))
      else $error("single length byte decoded above 127");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind mqtt_fixed_header_parser_core mfhp_checker #(.MAX_LEN_BYTES(MAX_LEN_BYTES)) u_mfhp_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_msg_type         (rsp_ch.msg_type),
   .rsp_remaining_length (rsp_ch.remaining_length),
   .rsp_header_bytes     (rsp_ch.header_bytes),
   .rsp_parse_status     (rsp_ch.parse_status)
);

FILE: test/mqtt_fixed_header_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mqtt_fixed_header_parser_core: feeds header bytes,
// predicts each result word in-bench and compares field by field.
// Depends on mfhp_pkg, mfhp_if and the parser RTL.
module mqtt_fixed_header_parser_core_tb;
   import mfhp_pkg::*;

   localparam int MAX_LEN    = 4;
   localparam int N_RANDOM   = 1450;
   localparam int LIMIT      = 200000;
   localparam int HOLD_AT    = 600;
   localparam int HOLD_LEN   = 250;
   localparam int CALM_FROM  = 1200;
   localparam int CALM_TO    = 1700;
   localparam int IDLE_PCT   = 26;
   localparam logic [27:0] LEN_ALL = 28'hFFF_FFFF;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } hdr_byte_type;

   typedef struct packed {
      logic [3:0]  msg_type;
      logic        dup;
      logic [1:0]  qos;
      logic        retain;
      logic [27:0] rem_len;
      logic [2:0]  hdr_cnt;
      logic [1:0]  status;
   } hdr_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfhp_req_if req_ch ();
   mfhp_rsp_if rsp_ch ();

   mqtt_fixed_header_parser_core #(.MAX_LEN_BYTES(MAX_LEN)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   hdr_byte_type   byte_q[$];
   hdr_result_type header_q[$];

   // predictor state
   logic        hdr_open   = 1'b0;
   logic [7:0]  first_hold = '0;
   logic [27:0] len_acc    = '0;
   int unsigned len_cnt    = 0;

   int cycle_cnt   = 0;
   int hold_left   = 0;
   int mismatches  = 0;
   int orphans     = 0;
   int n_ok        = 0;
   int n_incomp    = 0;
   int n_malformed = 0;
   int n_bytes     = 0;

   function automatic hdr_result_type make_result(logic [7:0] fb, logic [27:0] len,
                                                  logic [2:0] cnt, logic [1:0] st);
      hdr_result_type r;
      r.msg_type = fb[7:4];
      r.dup      = fb[3];
      r.qos      = fb[2:1];
      r.retain   = fb[0];
      r.rem_len  = len;
      r.hdr_cnt  = cnt;
      r.status   = st;
      return r;
   endfunction

   function void parse_byte(logic [7:0] b, logic last);
      logic [63:0] part;
      int unsigned sh;
      logic [31:0] cnt;
      if (!hdr_open) begin
         first_hold = b;
         len_acc    = '0;
         len_cnt    = 0;
         if (last)
            header_q.push_back(make_result(b, '0, '0, ST_INCOMPLETE));
         else
            hdr_open = 1'b1;
         return;
      end
      sh   = 7 * len_cnt;
      part = {57'd0, b[6:0]};
      if (part != 0) begin
         if (sh >= 28) begin
            len_acc = LEN_ALL;
         end else begin
            part = part << sh;
            if (part > {36'd0, LEN_ALL}) len_acc = LEN_ALL;
            else len_acc = len_acc | part[27:0];
         end
      end
      if (len_cnt < 15) len_cnt++;
      if (!b[7]) begin
         cnt = 1 + len_cnt;
         header_q.push_back(make_result(first_hold, len_acc, cnt[2:0], ST_OK));
         hdr_open = 1'b0;
      end else if (len_cnt >= MAX_LEN) begin
         header_q.push_back(make_result(first_hold, '0, '0, ST_MALFORMED));
         hdr_open = 1'b0;
      end else if (last) begin
         header_q.push_back(make_result(first_hold, '0, '0, ST_INCOMPLETE));
         hdr_open = 1'b0;
      end
   endfunction

   task automatic queue_byte(logic [7:0] b, logic last);
      hdr_byte_type w;
      w.data = b;
      w.last = last;
      byte_q.push_back(w);
   endtask

   // first byte plus a varint of nlen bytes (overlong forms allowed)
   task automatic queue_header(logic [7:0] fb, logic [27:0] value, int nlen, logic last);
      logic [27:0] v;
      v = value;
      queue_byte(fb, 1'b0);
      for (int i = 0; i < nlen; i++) begin
         queue_byte({(i != nlen - 1), v[6:0]}, (i == nlen - 1) ? last : 1'b0);
         v = v >> 7;
      end
   endtask

   // continuation-only length bytes; last one optionally marks buffer end
   task automatic queue_open_header(logic [7:0] fb, int nlen, logic last);
      queue_byte(fb, 1'b0);
      for (int i = 0; i < nlen; i++)
         queue_byte({1'b1, 7'($urandom)}, (i == nlen - 1) ? last : 1'b0);
   endtask

   task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                  $realtime, field, exp_v, got_v);
   endtask

   wire hold_on = (hold_left != 0);
   wire calm    = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

   // receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_cnt == HOLD_AT) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
         req_ch.buf_end   <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            parse_byte(req_ch.data_byte, req_ch.buf_end);
            n_bytes++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (byte_q.size() != 0 &&
                (calm || hold_on || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= byte_q[0].data;
               req_ch.buf_end   <= byte_q[0].last;
               void'(byte_q.pop_front());
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_on && (calm || $urandom_range(0, 99) >= IDLE_PCT);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (header_q.size() == 0) begin
               orphans++;
               $display("[%0t] result word with nothing expected", $realtime);
            end else begin
               if (rsp_ch.msg_type != header_q[0].msg_type)
                  note_mismatch("msg_type", header_q[0].msg_type, rsp_ch.msg_type);
               if (rsp_ch.dup_flag != header_q[0].dup)
                  note_mismatch("dup_flag", header_q[0].dup, rsp_ch.dup_flag);
               if (rsp_ch.qos_level != header_q[0].qos)
                  note_mismatch("qos_level", header_q[0].qos, rsp_ch.qos_level);
               if (rsp_ch.retain_flag != header_q[0].retain)
                  note_mismatch("retain_flag", header_q[0].retain, rsp_ch.retain_flag);
               if (rsp_ch.remaining_length != header_q[0].rem_len)
                  note_mismatch("remaining_length", header_q[0].rem_len,
                                rsp_ch.remaining_length);
               if (rsp_ch.header_bytes != header_q[0].hdr_cnt)
                  note_mismatch("header_bytes", header_q[0].hdr_cnt, rsp_ch.header_bytes);
               if (rsp_ch.parse_status != header_q[0].status)
                  note_mismatch("parse_status", header_q[0].status, rsp_ch.parse_status);
               case (header_q[0].status)
                  ST_OK:         n_ok++;
                  ST_INCOMPLETE: n_incomp++;
                  default:       n_malformed++;
               endcase
               void'(header_q.pop_front());
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int kind;
      int nlen;
      logic [27:0] value;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.buf_end   = 1'b0;
      rsp_ch.ready     = 1'b0;

      // directed
      queue_byte(8'h00, 1'b1);                    // buffer ends on first byte
      queue_header(8'h30, 28'd0, 1, 1'b0);        // zero length
      queue_header(8'hFF, 28'd127, 1, 1'b0);
      queue_header(8'h82, 28'd128, 2, 1'b1);      // buffer ends on closing byte
      queue_header(8'h6B, 28'd2097151, 3, 1'b0);
      queue_header(8'hC0, LEN_ALL, 4, 1'b0);      // largest length
      queue_byte(8'h10, 1'b0);                    // buffer ends inside the length
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hE0, 1'b0);                    // too many length bytes
      repeat (4) queue_byte(8'h80, 1'b0);
      queue_byte(8'h90, 1'b0);                    // malformed wins over buffer end
      repeat (3) queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);

      // random: mostly well-formed headers
      while (byte_q.size() < N_RANDOM + 27) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            nlen  = ($urandom_range(0, 3) == 0) ? 4 : $urandom_range(1, 3);
            value = 28'($urandom);
            case ($urandom_range(0, 5))
               0:       value = '0;
               1:       value = LEN_ALL;
               default: ;
            endcase
            if (nlen < 4) value = value & ((28'd1 << (7 * nlen)) - 28'd1);
            queue_header(8'($urandom), value, nlen, 1'($urandom));
         end else if (kind < 75) begin
            queue_byte(8'($urandom), 1'b1);
         end else if (kind < 85) begin
            queue_open_header(8'($urandom), $urandom_range(1, 3), 1'b1);
         end else if (kind < 93) begin
            queue_open_header(8'($urandom), 4, 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'($urandom));
         end
      end
      // buffer end closes whatever header the random tail left open
      queue_byte(8'hFF, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_ch.valid) @(posedge clock);
      while (header_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d header bytes taken; results: %0d ok, %0d incomplete, %0d malformed",
               n_bytes, n_ok, n_incomp, n_malformed);
      $display("%0d field mismatches, %0d unexpected words, %0d results never seen",
               mismatches, orphans, header_q.size());
      if (mismatches == 0 && orphans == 0 && header_q.size() == 0 && !hdr_open) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
design/mfhp_pkg.sv
design/mfhp_if.sv
design/mfhp_front.sv
design/mfhp_queue.sv
design/mfhp_back.sv
design/mqtt_fixed_header_parser_core.sv
design/mfhp_checker.sv
test/mqtt_fixed_header_parser_core_tb.sv
